/* hw/rtl/glp_pkg.sv */
// shared constants, codes and control types of the glyph index lookup engine
package glp_pkg;

    // table geometry
    localparam int MAX_ENTRIES = 4096;
    localparam int FRONT_SLOTS = 100;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int FP_W        = (FRONT_SLOTS > 1) ? $clog2(FRONT_SLOTS) : 1;

    // field widths
    localparam int ID_W      = 16;
    localparam int OFF_W     = 32;
    localparam int DIM_W     = 7;
    localparam int BYTES_W   = 10;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int ENTRY_W   = ID_W + OFF_W;
    localparam int PIX_W     = 2 * DIM_W;
    localparam int CEIL_W    = PIX_W + 1 - 3;

    // limits and reset values
    localparam logic [OFF_W-1:0]   DATA_MIN   = 32'd16;
    localparam logic [BYTES_W-1:0] BYTES_MAX  = 10'd1023;
    localparam logic [DIM_W-1:0]   DIM_RESET  = 7'd16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DATA_LEN = 2'd0,
        CFG_WIDTH    = 2'd1,
        CFG_HEIGHT   = 2'd2
    } cfg_reg_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_HIT    = 3'd0,
        ST_MISS   = 3'd1,
        ST_OOB    = 3'd2,
        ST_LOADED = 3'd3,
        ST_FULL   = 3'd4
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_CHECK,
        S_SWAP_K,
        S_SWAP_F,
        S_POST
    } state_t;

    // kind of result to stage
    typedef enum logic [2:0] {
        RK_LOADED,
        RK_FULL,
        RK_SHORT,
        RK_MISS,
        RK_LOOKUP
    } res_kind_t;

    // controller to datapath
    typedef struct packed {
        logic      capture;
        logic      load_write;
        logic      res_we;
        res_kind_t res_kind;
        logic      scan_first;
        logic      scan_next;
        logic      take_hit;
        logic      promote;
        logic      write_k;
        logic      write_f;
        logic      post;
    } glp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_load;
        logic is_full;
        logic is_short;
        logic is_empty;
        logic scan_match;
        logic scan_last;
        logic promote_due;
        logic out_free;
    } glp_stat_t;

endpackage

/* hw/rtl/glyph_index_lookup_promote.sv */
// top level of the glyph index lookup engine with front-slot promotion
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_mode, s_glyph_id, s_entry_offset
//  m_        out        m_valid / m_ready    m_status, m_glyph_offset, m_glyph_bytes
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A load word, or a lookup on short data or an empty table, goes from the dispatch
// state to the result register. Any other lookup scans the entries, one per cycle
// through the table ram read port; a hit then passes a check state and, when its
// index exceeds FRONT_SLOTS, the two swap writes; a miss ends at the last entry.
// Reset clears the entry count, front pointer, configuration registers and output valid; the table is not cleared.
// One word is in work at a time; the next is accepted as soon as its result sits in
// the output register, and a stalled m_ready holds that register and the next result.
module glyph_index_lookup_promote (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_mode,
    input  logic [glp_pkg::ID_W-1:0]      s_glyph_id,
    input  logic [glp_pkg::OFF_W-1:0]     s_entry_offset,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [glp_pkg::STATUS_W-1:0]  m_status,
    output logic [glp_pkg::OFF_W-1:0]     m_glyph_offset,
    output logic [glp_pkg::BYTES_W-1:0]   m_glyph_bytes,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [glp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [glp_pkg::OFF_W-1:0]     cfg_data
);
    import glp_pkg::*;

    glp_cmd_t  cmd;
    glp_stat_t stat;

    // sequencer
    glp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // table and arithmetic
    glp_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_mode         (s_mode),
        .s_glyph_id     (s_glyph_id),
        .s_entry_offset (s_entry_offset),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_glyph_offset (m_glyph_offset),
        .m_glyph_bytes  (m_glyph_bytes),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

/* hw/rtl/glp_ram.sv */
// generic single-port-write, single-port-read ram with registered read
module glp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/glp_ctrl.sv */
// sequencing state machine for load, scan, promotion swap and result hand-off
module glp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  glp_pkg::glp_stat_t stat,
    output glp_pkg::glp_cmd_t  cmd
);
    import glp_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.res_kind = RK_MISS;
        s_ready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (stat.is_load) begin
                    cmd.res_we = 1'b1;
                    if (stat.is_full) begin
                        cmd.res_kind = RK_FULL;
                    end else begin
                        cmd.res_kind   = RK_LOADED;
                        cmd.load_write = 1'b1;
                    end
                    state_next = S_POST;
                end else if (stat.is_short) begin
                    cmd.res_we   = 1'b1;
                    cmd.res_kind = RK_SHORT;
                    state_next   = S_POST;
                end else if (stat.is_empty) begin
                    cmd.res_we   = 1'b1;
                    cmd.res_kind = RK_MISS;
                    state_next   = S_POST;
                end else begin
                    cmd.scan_first = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (stat.scan_match) begin
                    cmd.take_hit = 1'b1;
                    state_next   = S_CHECK;
                end else if (stat.scan_last) begin
                    cmd.res_we   = 1'b1;
                    cmd.res_kind = RK_MISS;
                    state_next   = S_POST;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_CHECK: begin
                cmd.res_we   = 1'b1;
                cmd.res_kind = RK_LOOKUP;
                if (stat.promote_due) begin
                    cmd.promote = 1'b1;
                    state_next  = S_SWAP_K;
                end else begin
                    state_next = S_POST;
                end
            end
            S_SWAP_K: begin
                cmd.write_k = 1'b1;
                state_next  = S_SWAP_F;
            end
            S_SWAP_F: begin
                cmd.write_f = 1'b1;
                state_next  = S_POST;
            end
            S_POST: begin
                if (stat.out_free) begin
                    cmd.post   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/glp_dpath.sv */
// entry table, scan index, configuration registers, size and bounds logic, output word
module glp_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_mode,
    input  logic [glp_pkg::ID_W-1:0]      s_glyph_id,
    input  logic [glp_pkg::OFF_W-1:0]     s_entry_offset,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [glp_pkg::STATUS_W-1:0]  m_status,
    output logic [glp_pkg::OFF_W-1:0]     m_glyph_offset,
    output logic [glp_pkg::BYTES_W-1:0]   m_glyph_bytes,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [glp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [glp_pkg::OFF_W-1:0]     cfg_data,
    input  glp_pkg::glp_cmd_t             cmd,
    output glp_pkg::glp_stat_t            stat
);
    import glp_pkg::*;

    // configuration
    logic [OFF_W-1:0] fdl_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    // item and search state
    logic               mode_reg;
    logic [ID_W-1:0]    id_reg;
    logic [OFF_W-1:0]   off_reg;
    logic [BYTES_W-1:0] size_reg;
    logic [ADDR_W-1:0]  idx_reg;
    logic [ADDR_W-1:0]  hit_idx_reg;
    logic [OFF_W-1:0]   hit_off_reg;
    logic [CNT_W-1:0]   total_reg;
    logic [FP_W-1:0]    fp_reg;
    logic [FP_W-1:0]    fp_next;

    // staged result and output word
    status_t            res_status_reg;
    logic [OFF_W-1:0]   res_off_reg;
    logic [BYTES_W-1:0] res_bytes_reg;
    logic               m_valid_reg;
    status_t            m_status_reg;
    logic [OFF_W-1:0]   m_off_reg;
    logic [BYTES_W-1:0] m_bytes_reg;

    // ram ports
    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;

    // size and bounds
    logic [PIX_W-1:0]   pix;
    logic [PIX_W:0]     pix_round;
    logic [CEIL_W-1:0]  ceil_bytes;
    logic [BYTES_W-1:0] size_calc;
    logic [OFF_W:0]     end_sum;
    logic               in_bounds;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fdl_reg    <= '0;
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DATA_LEN: fdl_reg    <= cfg_data;
                CFG_WIDTH:    width_reg  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT:   height_reg <= cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // glyph size: ceil(w*h/8), saturated
    always_comb begin
        pix        = width_reg * height_reg;
        pix_round  = {1'b0, pix} + (PIX_W+1)'(7);
        ceil_bytes = pix_round[PIX_W:3];
        size_calc  = (ceil_bytes > CEIL_W'(BYTES_MAX)) ? BYTES_MAX : ceil_bytes[BYTES_W-1:0];
    end

    // bounds test on the hit without wrap
    always_comb begin
        end_sum   = {1'b0, hit_off_reg} + (OFF_W+1)'(size_reg);
        in_bounds = end_sum <= {1'b0, fdl_reg};
    end

    // rotating front pointer step
    always_comb begin
        if (fp_reg == FP_W'(FRONT_SLOTS - 1)) begin
            fp_next = '0;
        end else begin
            fp_next = fp_reg + FP_W'(1);
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg <= s_mode;
            id_reg   <= s_glyph_id;
            off_reg  <= s_entry_offset;
            size_reg <= size_calc;
        end
    end

    // scan index and hit capture
    always_ff @(posedge aclk) begin
        if (cmd.scan_first) begin
            idx_reg <= '0;
        end else if (cmd.scan_next) begin
            idx_reg <= idx_reg + ADDR_W'(1);
        end
        if (cmd.take_hit) begin
            hit_idx_reg <= idx_reg;
            hit_off_reg <= ram_rd_data[OFF_W-1:0];
        end
    end

    // entry count and front pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            fp_reg    <= '0;
        end else begin
            if (cmd.load_write) begin
                total_reg <= total_reg + CNT_W'(1);
            end
            if (cmd.promote) begin
                fp_reg <= fp_next;
            end
        end
    end

    // ram address and data selection
    always_comb begin
        ram_rd_en   = cmd.scan_first | cmd.scan_next | cmd.promote;
        ram_rd_addr = ADDR_W'(fp_next);
        if (cmd.scan_first) begin
            ram_rd_addr = '0;
        end else if (cmd.scan_next) begin
            ram_rd_addr = idx_reg + ADDR_W'(1);
        end
        ram_wr_en   = cmd.load_write | cmd.write_k | cmd.write_f;
        ram_wr_addr = total_reg[ADDR_W-1:0];
        ram_wr_data = {id_reg, off_reg};
        if (cmd.write_k) begin
            ram_wr_addr = hit_idx_reg;
            ram_wr_data = ram_rd_data;
        end else if (cmd.write_f) begin
            ram_wr_addr = ADDR_W'(fp_reg);
            ram_wr_data = {id_reg, hit_off_reg};
        end
    end

    // entry table: id in the upper bits, offset in the lower
    glp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // result staging
    always_ff @(posedge aclk) begin
        if (cmd.res_we) begin
            res_off_reg   <= '0;
            res_bytes_reg <= '0;
            case (cmd.res_kind)
                RK_LOADED: res_status_reg <= ST_LOADED;
                RK_FULL:   res_status_reg <= ST_FULL;
                RK_SHORT:  res_status_reg <= ST_MISS;
                RK_MISS: begin
                    res_status_reg <= ST_MISS;
                    res_bytes_reg  <= size_reg;
                end
                RK_LOOKUP: begin
                    if (in_bounds) begin
                        res_status_reg <= ST_HIT;
                        res_off_reg    <= hit_off_reg;
                        res_bytes_reg  <= size_reg;
                    end else begin
                        res_status_reg <= ST_OOB;
                    end
                end
                default: res_status_reg <= ST_MISS;
            endcase
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.post) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.post) begin
            m_status_reg <= res_status_reg;
            m_off_reg    <= res_off_reg;
            m_bytes_reg  <= res_bytes_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_glyph_offset = m_off_reg;
    assign m_glyph_bytes  = m_bytes_reg;

    // status to the controller
    always_comb begin
        stat.is_load     = ~mode_reg;
        stat.is_full     = (total_reg == CNT_W'(MAX_ENTRIES));
        stat.is_short    = (fdl_reg < DATA_MIN);
        stat.is_empty    = (total_reg == '0);
        stat.scan_match  = (ram_rd_data[ENTRY_W-1:OFF_W] == id_reg);
        stat.scan_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) == total_reg);
        stat.promote_due = (32'(hit_idx_reg) > 32'(FRONT_SLOTS));
        stat.out_free    = ~m_valid_reg | m_ready;
    end

endmodule

/* hw/rtl/glp_checker.sv */
// port-level checks of the glyph index lookup engine, bound to the top level
module glp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [glp_pkg::STATUS_W-1:0]  m_status,
    input logic [glp_pkg::OFF_W-1:0]     m_glyph_offset,
    input logic [glp_pkg::BYTES_W-1:0]   m_glyph_bytes
);
    import glp_pkg::*;

    // one word in work at a time: input closes right after an acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // only a hit carries an offset
    a_offset_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_HIT) |-> (m_glyph_offset == '0))
        else $error("non-hit word carries an offset");

    // size is only reported on a hit or a plain miss
    a_bytes_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_OOB || m_status == ST_LOADED || m_status == ST_FULL)
        |-> (m_glyph_bytes == '0))
        else $error("load, full or out-of-bounds word carries a size");

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_glyph_offset)
        && $stable(m_glyph_bytes))
        else $error("result word changed while stalled");

endmodule

bind glyph_index_lookup_promote glp_checker u_glp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_glyph_offset (m_glyph_offset),
    .m_glyph_bytes  (m_glyph_bytes)
);

/* tb/sv/glyph_table_scoreboard.sv */
// scoreboard for the glyph index lookup engine: shadow table, answer prediction and compare
`timescale 1ns / 1ps

module glyph_table_scoreboard (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_mode,
    input  logic [glp_pkg::ID_W-1:0]      s_glyph_id,
    input  logic [glp_pkg::OFF_W-1:0]     s_entry_offset,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [glp_pkg::STATUS_W-1:0]  m_status,
    input  logic [glp_pkg::OFF_W-1:0]     m_glyph_offset,
    input  logic [glp_pkg::BYTES_W-1:0]   m_glyph_bytes,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [glp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [glp_pkg::OFF_W-1:0]     cfg_data,
    output int                            fail_count,
    output int                            pending,
    output int                            answers_checked,
    output int                            promotions,
    output int                            pointer_wraps
);
    import glp_pkg::*;

    typedef struct packed {
        status_t            status;
        logic [OFF_W-1:0]   offset;
        logic [BYTES_W-1:0] bytes;
    } glyph_answer_t;

    // shadow copy of the table, the front pointer and the registers
    logic [ID_W-1:0]  shadow_id  [MAX_ENTRIES];
    logic [OFF_W-1:0] shadow_off [MAX_ENTRIES];
    int               stored;
    int               front_slot;
    logic [OFF_W-1:0] data_len;
    logic [DIM_W-1:0] glyph_w;
    logic [DIM_W-1:0] glyph_h;

    glyph_answer_t awaited_answers[$];

    // bitmap size: pixels over eight, rounded up, clipped to the field
    function automatic logic [BYTES_W-1:0] bitmap_bytes(input logic [DIM_W-1:0] w,
                                                        input logic [DIM_W-1:0] h);
        int pixels;
        int n;
        pixels = int'(w) * int'(h);
        n = (pixels + 7) / 8;
        if (n > int'(BYTES_MAX))
            n = int'(BYTES_MAX);
        return n[BYTES_W-1:0];
    endfunction

    // work out the answer to one accepted word and update the shadow table
    task automatic compute_answer(input bit is_lookup, input logic [ID_W-1:0] id,
                                  input logic [OFF_W-1:0] off);
        glyph_answer_t      ans;
        logic [BYTES_W-1:0] glyph_size;
        logic [OFF_W:0]     reach;
        logic [ID_W-1:0]    moved_id;
        logic [OFF_W-1:0]   moved_off;
        int                 k;
        bit                 found;

        glyph_size = bitmap_bytes(glyph_w, glyph_h);
        ans.status = ST_MISS;
        ans.offset = '0;
        ans.bytes  = '0;
        found      = 1'b0;
        k          = 0;
        if (!is_lookup) begin
            // append unless the table is already full
            if (stored >= MAX_ENTRIES) begin
                ans.status = ST_FULL;
            end else begin
                shadow_id[stored]  = id;
                shadow_off[stored] = off;
                stored++;
                ans.status = ST_LOADED;
            end
        end else if (data_len >= DATA_MIN) begin
            // first match in table order wins
            while (!found && k < stored) begin
                if (shadow_id[k] == id)
                    found = 1'b1;
                else
                    k++;
            end
            if (!found) begin
                ans.bytes = glyph_size;
            end else begin
                // bounds test on the wide sum, no wrap
                reach = {1'b0, shadow_off[k]} + (OFF_W+1)'(glyph_size);
                if (reach <= {1'b0, data_len}) begin
                    ans.status = ST_HIT;
                    ans.offset = shadow_off[k];
                    ans.bytes  = glyph_size;
                end else begin
                    ans.status = ST_OOB;
                end
                // a hit past index FRONT_SLOTS trades places with the next front slot
                if (k > FRONT_SLOTS) begin
                    front_slot++;
                    if (front_slot >= FRONT_SLOTS) begin
                        front_slot = 0;
                        pointer_wraps++;
                    end
                    moved_id               = shadow_id[k];
                    moved_off              = shadow_off[k];
                    shadow_id[k]           = shadow_id[front_slot];
                    shadow_off[k]          = shadow_off[front_slot];
                    shadow_id[front_slot]  = moved_id;
                    shadow_off[front_slot] = moved_off;
                    promotions++;
                end
            end
        end
        // short data falls through as not found with no size
        awaited_answers.push_back(ans);
    endtask

    task automatic check_field(input string what, input logic [OFF_W-1:0] want,
                               input logic [OFF_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
            fail_count++;
        end
    endtask

    // everything is sampled at the rising edge
    always @(posedge aclk) begin : watch
        glyph_answer_t want;
        if (!aresetn) begin
            awaited_answers.delete();
            stored     = 0;
            front_slot = 0;
            data_len   = '0;
            glyph_w    = DIM_RESET;
            glyph_h    = DIM_RESET;
        end else begin
            // result word against the oldest prediction
            if (m_valid && m_ready) begin
                answers_checked++;
                if (awaited_answers.size() == 0) begin
                    $display("%0t: result word with none awaited: status %0d offset 0x%0h bytes %0d",
                             $time, m_status, m_glyph_offset, m_glyph_bytes);
                    fail_count++;
                end else begin
                    want = awaited_answers.pop_front();
                    check_field("status", OFF_W'(want.status), OFF_W'(m_status));
                    check_field("glyph_offset", want.offset, m_glyph_offset);
                    check_field("glyph_bytes", OFF_W'(want.bytes), OFF_W'(m_glyph_bytes));
                end
            end
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DATA_LEN: data_len = cfg_data;
                    CFG_WIDTH:    glyph_w  = cfg_data[DIM_W-1:0];
                    CFG_HEIGHT:   glyph_h  = cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            // new input word
            if (s_valid && s_ready)
                compute_answer(s_mode, s_glyph_id, s_entry_offset);
        end
        pending = awaited_answers.size();
    end

endmodule

/* tb/sv/glyph_index_lookup_promote_tb.sv */
// testbench top for the glyph index lookup engine: stimulus, idling and verdict
`timescale 1ns / 1ps

module glyph_index_lookup_promote_tb;
    import glp_pkg::*;

    localparam int              CLK_PERIOD    = 10;
    localparam int              QUIET_LIMIT   = 25000;
    localparam int              RANDOM_WORDS  = 12;
    localparam int              ROUND_WORDS   = 6;
    localparam int              BUILD_ENTRIES = 112;
    localparam logic            MODE_LOAD     = 1'b0;
    localparam logic            MODE_LOOKUP   = 1'b1;
    localparam logic [ID_W-1:0] LAST_ID       = 16'hF00D;
    localparam logic [ID_W-1:0] GHOST_ID      = 16'hDEAD;

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic                  s_mode         = MODE_LOAD;
    logic [ID_W-1:0]       s_glyph_id     = '0;
    logic [OFF_W-1:0]      s_entry_offset = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [OFF_W-1:0]      m_glyph_offset;
    logic [BYTES_W-1:0]    m_glyph_bytes;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = CFG_DATA_LEN;
    logic [OFF_W-1:0]      cfg_data       = '0;

    int                    fail_count;
    int                    pending;
    int                    answers_checked;
    int                    promotions;
    int                    pointer_wraps;
    int                    words_sent  = 0;
    int                    quiet_cycles = 0;
    bit                    steady      = 1'b0;
    logic [ID_W-1:0]       loaded_ids[$];

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    glyph_index_lookup_promote u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_glyph_id     (s_glyph_id),
        .s_entry_offset (s_entry_offset),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_glyph_offset (m_glyph_offset),
        .m_glyph_bytes  (m_glyph_bytes),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    glyph_table_scoreboard u_scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_glyph_id      (s_glyph_id),
        .s_entry_offset  (s_entry_offset),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_glyph_offset  (m_glyph_offset),
        .m_glyph_bytes   (m_glyph_bytes),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .answers_checked (answers_checked),
        .promotions      (promotions),
        .pointer_wraps   (pointer_wraps)
    );

    // result side stalls about one cycle in seven unless running steady
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 14);
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("glyph_index_lookup_promote_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // random id that keeps clear of the two reserved ones
    function automatic logic [ID_W-1:0] fresh_id();
        logic [ID_W-1:0] id;
        do begin
            id = ID_W'($urandom_range(0, 16'hFFFF));
        end while (id == LAST_ID || id == GHOST_ID);
        return id;
    endfunction

    // mostly offsets that fit a moderate font, sometimes any 32-bit value
    function automatic logic [OFF_W-1:0] pick_offset();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return $urandom_range(0, 32'h0010_0000);
    endfunction

    // present one word and hold it until accepted
    task automatic push_word(input logic mode, input logic [ID_W-1:0] id,
                             input logic [OFF_W-1:0] off);
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < 14) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_mode         = mode;
        s_glyph_id     = id;
        s_entry_offset = off;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        words_sent++;
        if (mode == MODE_LOAD && loaded_ids.size() < MAX_ENTRIES)
            loaded_ids.push_back(id);
    endtask

    // stop sending and wait for every awaited result
    task automatic await_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [OFF_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    initial begin : stimulus
        int pick;
        int slot;
        int round;
        int sent_random;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // zero data length after reset: short data, empty and loaded table alike
        push_word(MODE_LOOKUP, 16'h0000, 32'h0000_0000);
        push_word(MODE_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF);
        push_word(MODE_LOAD, 16'h0041, 32'd15);
        push_word(MODE_LOAD, 16'h0042, 32'd16);
        push_word(MODE_LOAD, 16'hFFFF, 32'hFFFF_FFFF);
        push_word(MODE_LOAD, 16'h0041, 32'd0);
        push_word(MODE_LOAD, 16'h0000, 32'h8000_0000);
        push_word(MODE_LOOKUP, 16'h0041, 32'h0);
        await_idle();
        write_reg(CFG_DATA_LEN, 32'd15);
        push_word(MODE_LOOKUP, 16'h0041, 32'h0);

        // one-byte glyphs in a 16-byte font
        await_idle();
        write_reg(CFG_DATA_LEN, 32'd16);
        write_reg(CFG_WIDTH, 32'd1);
        write_reg(CFG_HEIGHT, 32'd1);
        push_word(MODE_LOOKUP, 16'h0041, 32'h0);    // first of two matches, ends on the limit
        push_word(MODE_LOOKUP, 16'h0042, 32'h0);    // one byte past the end
        push_word(MODE_LOOKUP, 16'hFFFF, 32'h0);    // sum would wrap in 32 bits
        push_word(MODE_LOOKUP, 16'h1234, 32'h0);    // plain miss
        push_word(MODE_LOOKUP, 16'h0000, 32'h0);

        // zero width: empty bitmap sits right at the end
        await_idle();
        write_reg(CFG_WIDTH, 32'd0);
        push_word(MODE_LOOKUP, 16'h0042, 32'h0);

        // oversized dimensions saturate the size
        await_idle();
        write_reg(CFG_DATA_LEN, 32'hFFFF_FFFF);
        write_reg(CFG_WIDTH, 32'd127);
        write_reg(CFG_HEIGHT, 32'd127);
        push_word(MODE_LOOKUP, 16'hFFFF, 32'h0);
        push_word(MODE_LOOKUP, 16'h0000, 32'h0);
        push_word(MODE_LOOKUP, 16'h7777, 32'h0);

        // a 64 by 64 glyph, then a size that needs rounding up
        await_idle();
        write_reg(CFG_WIDTH, 32'd64);
        write_reg(CFG_HEIGHT, 32'd64);
        push_word(MODE_LOOKUP, 16'h0041, 32'h0);
        await_idle();
        write_reg(CFG_WIDTH, 32'd3);
        write_reg(CFG_HEIGHT, 32'd3);
        push_word(MODE_LOOKUP, 16'h0042, 32'h0);

        // grow the table past the front slots with no idling on either side,
        // ending on a marker glyph
        await_idle();
        write_reg(CFG_WIDTH, 32'd8);
        write_reg(CFG_HEIGHT, 32'd8);
        steady = 1'b1;
        for (slot = loaded_ids.size(); slot < BUILD_ENTRIES - 1; slot++)
            push_word(MODE_LOAD, {4'hA, slot[11:0]}, pick_offset());
        push_word(MODE_LOAD, LAST_ID, 32'h0000_1000);
        steady = 1'b0;

        // last entry that stays put, then the first one that gets promoted
        push_word(MODE_LOOKUP, loaded_ids[FRONT_SLOTS], $urandom);
        push_word(MODE_LOOKUP, loaded_ids[FRONT_SLOTS + 1], $urandom);

        // random rounds, each under a fresh register setting
        round       = 0;
        sent_random = 0;
        while (sent_random < RANDOM_WORDS) begin
            await_idle();
            steady = (round == 1);
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_DATA_LEN, 32'hFFFF_FFFF);
                1:       write_reg(CFG_DATA_LEN, $urandom);
                2:       write_reg(CFG_DATA_LEN, $urandom_range(16, 32'h0020_0000));
                default: write_reg(CFG_DATA_LEN, $urandom_range(0, 40));
            endcase
            write_reg(CFG_WIDTH, ($urandom_range(0, 7) == 0) ? 32'd127 : $urandom_range(1, 64));
            write_reg(CFG_HEIGHT, $urandom_range(0, 64));
            repeat (ROUND_WORDS) begin
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    push_word(MODE_LOAD, fresh_id(), pick_offset());
                end else if (pick < 25) begin
                    push_word(MODE_LOOKUP, fresh_id(), $urandom);
                end else begin
                    // known glyphs, mostly from behind the front slots
                    if ($urandom_range(0, 4) != 0)
                        slot = $urandom_range(FRONT_SLOTS + 1, loaded_ids.size() - 1);
                    else
                        slot = $urandom_range(0, loaded_ids.size() - 1);
                    push_word(MODE_LOOKUP, loaded_ids[slot], $urandom);
                end
                sent_random++;
            end
            round++;
        end
        steady = 1'b0;

        // lookups under the largest data length: marker glyph twice, an absent glyph, the oldest entry
        await_idle();
        write_reg(CFG_DATA_LEN, 32'hFFFF_FFFF);
        write_reg(CFG_WIDTH, 32'd64);
        write_reg(CFG_HEIGHT, 32'd64);
        push_word(MODE_LOOKUP, LAST_ID, 32'h0);
        push_word(MODE_LOOKUP, LAST_ID, 32'h0);
        push_word(MODE_LOOKUP, GHOST_ID, 32'h0);
        push_word(MODE_LOOKUP, loaded_ids[0], 32'h0);
        await_idle();
        repeat (16) @(negedge aclk);

        $display("covered %0d words, %0d results checked, table filled to %0d entries",
                 words_sent, answers_checked, loaded_ids.size());
        $display("%0d front-slot promotions, front pointer wrapped %0d times",
                 promotions, pointer_wraps);
        if (fail_count == 0 && pending == 0) begin
            $display("glyph_index_lookup_promote_tb: done, clean");
        end else begin
            $display("%0d mismatches, %0d results never arrived", fail_count, pending);
            $display("glyph_index_lookup_promote_tb: done, errors");
        end
        $finish;
    end

endmodule
